FILE: rtl/core/gcst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcst_pkg: shared types and codes of the connection slot table
// Request word, result word, slot record, and the command and status
// groups between controller and datapath.
// ----------------------------------------------------------------------------
package gcst_pkg;

   localparam logic [2:0] OP_CONN_USB = 3'd0;
   localparam logic [2:0] OP_CONN_BT  = 3'd1;
   localparam logic [2:0] OP_DISC_ID  = 3'd2;
   localparam logic [2:0] OP_DISC_USB = 3'd3;
   localparam logic [2:0] OP_DISC_BT  = 3'd4;
   localparam logic [2:0] OP_LOOKUP   = 3'd5;

   localparam logic [1:0] TR_USB     = 2'd0;
   localparam logic [1:0] TR_CLASSIC = 2'd1;
   localparam logic [1:0] TR_LE      = 2'd2;

   localparam logic [1:0] RK_FAIL  = 2'd0;
   localparam logic [1:0] RK_HIT   = 2'd1;
   localparam logic [1:0] RK_CHECK = 2'd2;
   localparam logic [1:0] RK_CLAIM = 2'd3;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [1:0]  transport;
      logic [6:0]  usb_address;
      logic [7:0]  usb_interface;
      logic [11:0] bt_connection;
      logic [7:0]  bt_service;
      logic [15:0] vendor_id;
      logic [15:0] product_id;
      logic [3:0]  protocol;
      logic [7:0]  slot_index;
      logic [15:0] slot_generation;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [2:0]  id_index;
      logic [15:0] id_generation;
      logic [1:0]  found_transport;
      logic [3:0]  found_protocol;
      logic [15:0] found_vendor;
      logic [15:0] found_product;
   } result_type;

   typedef struct packed {
      logic [1:0]  transport;
      logic [3:0]  protocol;
      logic [15:0] vendor;
      logic [15:0] product;
      logic [6:0]  usb_address;
      logic [7:0]  usb_interface;
      logic [11:0] bt_connection;
      logic [7:0]  bt_service;
      logic [15:0] generation;
   } slot_rec_type;

   typedef struct packed {
      logic       take;
      logic       start;
      logic       rd_en;
      logic       rd_use_id;
      logic       res_en;
      logic [1:0] res_kind;
      logic       push;
   } ctl_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic op_scan;
      logic op_check;
      logic rd_vld;
      logic hit;
      logic last;
      logic free_found;
      logic is_connect;
      logic rsp_free;
   } dp_status_type;

endpackage
`default_nettype wire

FILE: rtl/core/gcst_channels.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcst_channels: request and response channels
// Valid/ready channels carrying one request word and one result word.
// ----------------------------------------------------------------------------
interface gcst_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [1:0]  transport;
   logic [6:0]  usb_address;
   logic [7:0]  usb_interface;
   logic [11:0] bt_connection;
   logic [7:0]  bt_service;
   logic [15:0] vendor_id;
   logic [15:0] product_id;
   logic [3:0]  protocol;
   logic [7:0]  slot_index;
   logic [15:0] slot_generation;

   modport source (
      output valid, opcode, transport, usb_address, usb_interface, bt_connection,
             bt_service, vendor_id, product_id, protocol, slot_index, slot_generation,
      input  ready
   );
   modport sink (
      input  valid, opcode, transport, usb_address, usb_interface, bt_connection,
             bt_service, vendor_id, product_id, protocol, slot_index, slot_generation,
      output ready
   );
endinterface

interface gcst_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [2:0]  id_index;
   logic [15:0] id_generation;
   logic [1:0]  found_transport;
   logic [3:0]  found_protocol;
   logic [15:0] found_vendor;
   logic [15:0] found_product;

   modport source (
      output valid, ok, id_index, id_generation, found_transport, found_protocol,
             found_vendor, found_product,
      input  ready
   );
   modport sink (
      input  valid, ok, id_index, id_generation, found_transport, found_protocol,
             found_vendor, found_product,
      output ready
   );
endinterface
`default_nettype wire

FILE: rtl/core/gcst_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcst_ctrl: slot table sequencer
// Steps each request through decode, slot scan or id check, claim and
// response, and counts the scan address.
// ----------------------------------------------------------------------------
module gcst_ctrl
   import gcst_pkg::*;
#(
   parameter int SLOTS = 8,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int CNT_W = $clog2(SLOTS + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dp_status_type    st,
   output ctl_cmd_type           cmd,
   output logic [IDX_W-1:0]      rd_addr
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_CLAIM  = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             more;

   assign more    = cnt_ff < CNT_W'(SLOTS);
   assign rd_addr = cnt_ff[IDX_W-1:0];

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.take = 1'b1;
            if (st.req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (st.op_scan) begin
               cmd.start = 1'b1;
               cnt_in    = '0;
               state_in  = S_SCAN;
            end else if (st.op_check) begin
               cmd.rd_en     = 1'b1;
               cmd.rd_use_id = 1'b1;
               state_in      = S_CHECK;
            end else begin
               cmd.res_en   = 1'b1;
               cmd.res_kind = RK_FAIL;
               state_in     = S_RESP;
            end
         end
         S_SCAN: begin
            if (more) begin
               cmd.rd_en = 1'b1;
               cnt_in    = cnt_ff + CNT_W'(1);
            end
            if (st.rd_vld && st.hit) begin
               cmd.res_en   = 1'b1;
               cmd.res_kind = RK_HIT;
               state_in     = S_RESP;
            end else if (st.rd_vld && st.last) begin
               if (st.is_connect && st.free_found) begin
                  state_in = S_CLAIM;
               end else begin
                  cmd.res_en   = 1'b1;
                  cmd.res_kind = RK_FAIL;
                  state_in     = S_RESP;
               end
            end
         end
         S_CHECK: begin
            cmd.res_en   = 1'b1;
            cmd.res_kind = RK_CHECK;
            state_in     = S_RESP;
         end
         S_CLAIM: begin
            cmd.res_en   = 1'b1;
            cmd.res_kind = RK_CLAIM;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (st.rsp_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/gcst_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcst_datapath: slot store and result path
// Holds the request word, the slot record memory with its connected and
// used flags, the scan compare, the free slot tracker and the result words.
// ----------------------------------------------------------------------------
module gcst_datapath
   import gcst_pkg::*;
#(
   parameter int SLOTS = 8,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   gcst_req_if.sink           req_bus,
   gcst_rsp_if.source         rsp_bus,
   input  wire ctl_cmd_type   cmd,
   input  wire logic [IDX_W-1:0] rd_addr,
   output dp_status_type      st
);

   req_type            req_ff;
   slot_rec_type       mem [SLOTS];
   slot_rec_type       rd_rec_ff;
   slot_rec_type       wr_rec;
   logic [SLOTS-1:0]   conn_ff;
   logic [SLOTS-1:0]   used_ff;
   logic [IDX_W-1:0]   raddr;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic               rd_vld_ff;
   logic               rd_conn_ff;
   logic               rd_used_ff;
   logic [15:0]        rd_gen;
   logic               free_found_ff;
   logic [IDX_W-1:0]   free_idx_ff;
   logic [15:0]        free_gen_ff;
   logic [15:0]        new_gen;
   logic [7:0]         rd_idx_wide;
   logic [7:0]         free_idx_wide;
   logic               is_connect;
   logic               usb_op;
   logic               usb_hit;
   logic               bt_hit;
   logic               id_ok;
   logic               in_range;
   logic               do_clear;
   logic               do_claim;
   result_type         res_in;
   result_type         res_ff;
   result_type         rsp_ff;
   logic               rsp_valid_ff;

   function automatic logic is_bt(input logic [1:0] t);
      return (t == TR_CLASSIC) || (t == TR_LE);
   endfunction

   assign raddr         = cmd.rd_use_id ? req_ff.slot_index[IDX_W-1:0] : rd_addr;
   assign rd_gen        = rd_used_ff ? rd_rec_ff.generation : 16'd0;
   assign rd_idx_wide   = 8'(rd_idx_ff);
   assign free_idx_wide = 8'(free_idx_ff);
   assign new_gen       = (free_gen_ff == 16'hFFFF) ? 16'd1 : free_gen_ff + 16'd1;
   assign in_range      = {1'b0, req_ff.slot_index} < 9'(SLOTS);
   assign is_connect    = (req_ff.opcode == OP_CONN_USB) || (req_ff.opcode == OP_CONN_BT);
   assign usb_op        = (req_ff.opcode == OP_CONN_USB) || (req_ff.opcode == OP_DISC_USB);

   assign usb_hit = rd_conn_ff && (rd_rec_ff.transport == TR_USB)
                  && (rd_rec_ff.usb_address == req_ff.usb_address)
                  && (rd_rec_ff.usb_interface == req_ff.usb_interface);
   assign bt_hit  = rd_conn_ff && is_bt(rd_rec_ff.transport)
                  && (rd_rec_ff.transport == req_ff.transport)
                  && (rd_rec_ff.bt_connection == req_ff.bt_connection)
                  && (rd_rec_ff.bt_service == req_ff.bt_service);
   assign id_ok   = (req_ff.slot_generation != 16'd0) && rd_conn_ff
                  && (rd_gen == req_ff.slot_generation);

   assign st.req_valid  = req_bus.valid;
   assign st.op_scan    = (req_ff.opcode == OP_CONN_USB)
                        || ((req_ff.opcode == OP_CONN_BT) && is_bt(req_ff.transport))
                        || (req_ff.opcode == OP_DISC_USB)
                        || (req_ff.opcode == OP_DISC_BT);
   assign st.op_check   = ((req_ff.opcode == OP_DISC_ID) || (req_ff.opcode == OP_LOOKUP))
                        && in_range;
   assign st.rd_vld     = rd_vld_ff;
   assign st.hit        = usb_op ? usb_hit : bt_hit;
   assign st.last       = rd_idx_ff == IDX_W'(SLOTS - 1);
   assign st.free_found = free_found_ff || (rd_vld_ff && !rd_conn_ff);
   assign st.is_connect = is_connect;
   assign st.rsp_free   = !rsp_valid_ff || rsp_bus.ready;

   assign do_clear = cmd.res_en
                   && (((cmd.res_kind == RK_HIT) && !is_connect)
                      || ((cmd.res_kind == RK_CHECK) && id_ok
                         && (req_ff.opcode == OP_DISC_ID)));
   assign do_claim = cmd.res_en && (cmd.res_kind == RK_CLAIM);

   always_comb begin
      wr_rec               = '0;
      wr_rec.transport     = (req_ff.opcode == OP_CONN_USB) ? TR_USB : req_ff.transport;
      wr_rec.protocol      = req_ff.protocol;
      wr_rec.vendor        = req_ff.vendor_id;
      wr_rec.product       = req_ff.product_id;
      wr_rec.generation    = new_gen;
      if (req_ff.opcode == OP_CONN_USB) begin
         wr_rec.usb_address   = req_ff.usb_address;
         wr_rec.usb_interface = req_ff.usb_interface;
      end else begin
         wr_rec.bt_connection = req_ff.bt_connection;
         wr_rec.bt_service    = req_ff.bt_service;
      end
   end

   always_comb begin
      res_in = '0;
      case (cmd.res_kind)
         RK_HIT: begin
            res_in.ok = 1'b1;
            if (is_connect) begin
               res_in.id_index      = rd_idx_wide[2:0];
               res_in.id_generation = rd_gen;
            end
         end
         RK_CHECK: begin
            if (id_ok) begin
               res_in.ok = 1'b1;
               if (req_ff.opcode == OP_LOOKUP) begin
                  res_in.id_index        = req_ff.slot_index[2:0];
                  res_in.id_generation   = rd_gen;
                  res_in.found_transport = rd_rec_ff.transport;
                  res_in.found_protocol  = rd_rec_ff.protocol;
                  res_in.found_vendor    = rd_rec_ff.vendor;
                  res_in.found_product   = rd_rec_ff.product;
               end
            end
         end
         RK_CLAIM: begin
            res_in.ok            = 1'b1;
            res_in.id_index      = free_idx_wide[2:0];
            res_in.id_generation = new_gen;
         end
         default: begin
            res_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.take && req_bus.valid) begin
         req_ff.opcode          <= req_bus.opcode;
         req_ff.transport       <= req_bus.transport;
         req_ff.usb_address     <= req_bus.usb_address;
         req_ff.usb_interface   <= req_bus.usb_interface;
         req_ff.bt_connection   <= req_bus.bt_connection;
         req_ff.bt_service      <= req_bus.bt_service;
         req_ff.vendor_id       <= req_bus.vendor_id;
         req_ff.product_id      <= req_bus.product_id;
         req_ff.protocol        <= req_bus.protocol;
         req_ff.slot_index      <= req_bus.slot_index;
         req_ff.slot_generation <= req_bus.slot_generation;
      end
      if (do_claim) begin
         mem[free_idx_ff] <= wr_rec;
      end
      if (cmd.rd_en) begin
         rd_rec_ff  <= mem[raddr];
         rd_idx_ff  <= raddr;
         rd_conn_ff <= conn_ff[raddr];
         rd_used_ff <= used_ff[raddr];
      end
      if (!free_found_ff && rd_vld_ff && !rd_conn_ff) begin
         free_idx_ff <= rd_idx_ff;
         free_gen_ff <= rd_gen;
      end
      if (cmd.res_en) begin
         res_ff <= res_in;
      end
      if (cmd.push) begin
         rsp_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conn_ff       <= '0;
         used_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_en;
         if (cmd.start) begin
            free_found_ff <= 1'b0;
         end else if (rd_vld_ff && !rd_conn_ff) begin
            free_found_ff <= 1'b1;
         end
         if (do_clear) begin
            conn_ff[rd_idx_ff] <= 1'b0;
         end
         if (do_claim) begin
            conn_ff[free_idx_ff] <= 1'b1;
            used_ff[free_idx_ff] <= 1'b1;
         end
         if (cmd.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_bus.ready           = cmd.take;
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.ok              = rsp_ff.ok;
   assign rsp_bus.id_index        = rsp_ff.id_index;
   assign rsp_bus.id_generation   = rsp_ff.id_generation;
   assign rsp_bus.found_transport = rsp_ff.found_transport;
   assign rsp_bus.found_protocol  = rsp_ff.found_protocol;
   assign rsp_bus.found_vendor    = rsp_ff.found_vendor;
   assign rsp_bus.found_product   = rsp_ff.found_product;

endmodule
`default_nettype wire

FILE: rtl/core/generational_connection_slot_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// generational_connection_slot_table: connection slot table with generations
// Connect, disconnect and look up USB and Bluetooth connections by handle
// or by generation-tagged slot id.
//
//   channel  | dir | word
//   ---------+-----+------------------------------------------------------
//   req_bus  | in  | opcode, transport, handles, vendor/product, protocol, id
//   rsp_bus  | out | ok, id index/generation, stored slot fields
//
// A scanning request (connect, disconnect by handle) walks the one-port slot
// memory a slot per cycle. Id requests read one slot; rejected requests read
// none. The next request can be taken as soon as the result word goes valid.
// Reset clears the connected and used flags at once; no clearing pass.
// A result word not yet taken holds the following one in its final step.
// ----------------------------------------------------------------------------
module generational_connection_slot_table
   import gcst_pkg::*;
#(
   parameter int SLOTS = 8
) (
   input  wire logic   clock,
   input  wire logic   reset,
   gcst_req_if.sink    req_bus,
   gcst_rsp_if.source  rsp_bus
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   ctl_cmd_type      cmd;
   dp_status_type    st;
   logic [IDX_W-1:0] rd_addr;

   gcst_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .st      (st),
      .cmd     (cmd),
      .rd_addr (rd_addr)
   );

   gcst_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .cmd     (cmd),
      .rd_addr (rd_addr),
      .st      (st)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request taken while another is in flight");

   a_rsp_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(cmd.push))
      else $error("response raised without a push");

   a_claim_on_connect: assert property (@(posedge clock) disable iff (reset)
      (cmd.res_en && (cmd.res_kind == RK_CLAIM)) |-> st.is_connect)
      else $error("slot claimed for a non-connect request");

endmodule
`default_nettype wire

FILE: tb/sv/gcst_slot_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcst_slot_checker: answer predictor and scoreboard for the slot table
// Watches both channels, keeps its own copy of the slot table, works out the
// answer word for every accepted request and compares each accepted answer,
// field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module gcst_slot_checker
   import gcst_pkg::*;
#(
   parameter int SLOTS = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   gcst_req_if       req_bus,
   gcst_rsp_if       rsp_bus,
   output int        fail_count,
   output int        pending,
   output int        words_checked,
   output int        ok_count
);

   logic         live  [SLOTS];
   slot_rec_type slots [SLOTS];
   result_type   answers_due [$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_count < 40)
         $display("error at %0t: %s got %0h want %0h", $time, what, got, want);
      fail_count++;
   endtask

   function automatic int find_usb(input logic [6:0] addr, input logic [7:0] intf);
      int k;
      for (k = 0; k < SLOTS; k++)
         if (live[k] && slots[k].transport == TR_USB && slots[k].usb_address == addr &&
             slots[k].usb_interface == intf)
            return k;
      return -1;
   endfunction

   function automatic int find_bt(input logic [1:0] tr, input logic [11:0] conn,
                                  input logic [7:0] svc);
      int k;
      for (k = 0; k < SLOTS; k++)
         if (live[k] && (slots[k].transport == TR_CLASSIC || slots[k].transport == TR_LE) &&
             slots[k].transport == tr && slots[k].bt_connection == conn &&
             slots[k].bt_service == svc)
            return k;
      return -1;
   endfunction

   function automatic int claim_slot(input logic [1:0] tr, input req_type w);
      int k;
      logic [15:0] gen;
      for (k = 0; k < SLOTS; k++) begin
         if (!live[k]) begin
            gen = slots[k].generation + 16'd1;
            if (gen == 16'd0)
               gen = 16'd1;
            slots[k] = '0;
            slots[k].generation = gen;
            slots[k].transport = tr;
            slots[k].protocol = w.protocol;
            slots[k].vendor = w.vendor_id;
            slots[k].product = w.product_id;
            live[k] = 1'b1;
            return k;
         end
      end
      return -1;
   endfunction

   function automatic int check_id(input logic [7:0] idx, input logic [15:0] gen);
      if (gen == 16'd0 || 32'(idx) >= SLOTS)
         return -1;
      if (!live[idx] || slots[idx].generation != gen)
         return -1;
      return int'(idx);
   endfunction

   // keep transport and generation
   function automatic void clear_slot(input int k);
      live[k] = 1'b0;
      slots[k].protocol = '0;
      slots[k].vendor = '0;
      slots[k].product = '0;
      slots[k].usb_address = '0;
      slots[k].usb_interface = '0;
      slots[k].bt_connection = '0;
      slots[k].bt_service = '0;
   endfunction

   function automatic result_type predict_answer(input req_type w);
      result_type r;
      int s;
      r = '0;
      s = -1;
      case (w.opcode)
         OP_CONN_USB: begin
            s = find_usb(w.usb_address, w.usb_interface);
            if (s < 0) begin
               s = claim_slot(TR_USB, w);
               if (s >= 0) begin
                  slots[s].usb_address = w.usb_address;
                  slots[s].usb_interface = w.usb_interface;
               end
            end
         end
         OP_CONN_BT: begin
            if (w.transport == TR_CLASSIC || w.transport == TR_LE) begin
               s = find_bt(w.transport, w.bt_connection, w.bt_service);
               if (s < 0) begin
                  s = claim_slot(w.transport, w);
                  if (s >= 0) begin
                     slots[s].bt_connection = w.bt_connection;
                     slots[s].bt_service = w.bt_service;
                  end
               end
            end
         end
         OP_DISC_ID, OP_DISC_USB, OP_DISC_BT: begin
            if (w.opcode == OP_DISC_ID)
               s = check_id(w.slot_index, w.slot_generation);
            else if (w.opcode == OP_DISC_USB)
               s = find_usb(w.usb_address, w.usb_interface);
            else
               s = find_bt(w.transport, w.bt_connection, w.bt_service);
            if (s >= 0) begin
               clear_slot(s);
               r.ok = 1'b1;
            end
            return r;
         end
         OP_LOOKUP: begin
            s = check_id(w.slot_index, w.slot_generation);
            if (s >= 0) begin
               r.found_transport = slots[s].transport;
               r.found_protocol = slots[s].protocol;
               r.found_vendor = slots[s].vendor;
               r.found_product = slots[s].product;
            end
         end
         default: return r;
      endcase
      if (s >= 0) begin
         r.ok = 1'b1;
         r.id_index = s[2:0];
         r.id_generation = slots[s].generation;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      req_type    w;
      result_type got;
      result_type want;
      int         k;
      if (reset) begin
         for (k = 0; k < SLOTS; k++) begin
            live[k] = 1'b0;
            slots[k] = '0;
         end
         answers_due.delete();
         fail_count = 0;
         pending = 0;
         words_checked = 0;
         ok_count = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.ok = rsp_bus.ok;
            got.id_index = rsp_bus.id_index;
            got.id_generation = rsp_bus.id_generation;
            got.found_transport = rsp_bus.found_transport;
            got.found_protocol = rsp_bus.found_protocol;
            got.found_vendor = rsp_bus.found_vendor;
            got.found_product = rsp_bus.found_product;
            if (answers_due.size() == 0) begin
               report_mismatch("answer with no request outstanding, ok", 32'(got.ok), 32'd0);
            end else begin
               want = answers_due.pop_front();
               if (got.ok != want.ok)
                  report_mismatch("ok", 32'(got.ok), 32'(want.ok));
               if (got.id_index != want.id_index)
                  report_mismatch("id_index", 32'(got.id_index), 32'(want.id_index));
               if (got.id_generation != want.id_generation)
                  report_mismatch("id_generation", 32'(got.id_generation),
                                  32'(want.id_generation));
               if (got.found_transport != want.found_transport)
                  report_mismatch("found_transport", 32'(got.found_transport),
                                  32'(want.found_transport));
               if (got.found_protocol != want.found_protocol)
                  report_mismatch("found_protocol", 32'(got.found_protocol),
                                  32'(want.found_protocol));
               if (got.found_vendor != want.found_vendor)
                  report_mismatch("found_vendor", 32'(got.found_vendor),
                                  32'(want.found_vendor));
               if (got.found_product != want.found_product)
                  report_mismatch("found_product", 32'(got.found_product),
                                  32'(want.found_product));
               words_checked++;
               if (want.ok)
                  ok_count++;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            w.opcode = req_bus.opcode;
            w.transport = req_bus.transport;
            w.usb_address = req_bus.usb_address;
            w.usb_interface = req_bus.usb_interface;
            w.bt_connection = req_bus.bt_connection;
            w.bt_service = req_bus.bt_service;
            w.vendor_id = req_bus.vendor_id;
            w.product_id = req_bus.product_id;
            w.protocol = req_bus.protocol;
            w.slot_index = req_bus.slot_index;
            w.slot_generation = req_bus.slot_generation;
            answers_due.push_back(predict_answer(w));
         end
         pending = answers_due.size();
      end
   end

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the connection slot table
// Drives a directed set of connects, disconnects and lookups at the field
// extremes, repeated claims of one slot, then random traffic on small
// handle pools with random idling on both sides and one long answer stall.
// ----------------------------------------------------------------------------
module testbench;
   import gcst_pkg::*;

   localparam int SLOTS        = 8;
   localparam int RANDOM_WORDS = 775;
   localparam int HOLD_CYCLES  = 300;
   localparam int WRAP_PAIRS   = 20;
   // longest quiet stretch is the answer stall plus one scan
   localparam int IDLE_LIMIT   = 2000;

   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   localparam logic [1:0] TR_OTHER   = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm = 1'b0;
   int   holds_asked = 0;
   int   holds_done = 0;
   int   words_sent = 0;
   int   idle_cycles;
   int   fail_count;
   int   pending;
   int   words_checked;
   int   ok_count;
   logic [15:0] known_gen [SLOTS];

   gcst_req_if req_bus ();
   gcst_rsp_if rsp_bus ();

   generational_connection_slot_table #(.SLOTS(SLOTS)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   gcst_slot_checker #(.SLOTS(SLOTS)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fail_count    (fail_count),
      .pending       (pending),
      .words_checked (words_checked),
      .ok_count      (ok_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // remember the latest generation seen per slot
   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SLOTS; k++)
            known_gen[k] <= '0;
      end else if (rsp_bus.valid && rsp_bus.ready && rsp_bus.ok &&
                   rsp_bus.id_generation != 16'd0) begin
         known_gen[rsp_bus.id_index] <= rsp_bus.id_generation;
      end
   end

   task automatic send_word(input req_type w);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 7) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.opcode = w.opcode;
      req_bus.transport = w.transport;
      req_bus.usb_address = w.usb_address;
      req_bus.usb_interface = w.usb_interface;
      req_bus.bt_connection = w.bt_connection;
      req_bus.bt_service = w.bt_service;
      req_bus.vendor_id = w.vendor_id;
      req_bus.product_id = w.product_id;
      req_bus.protocol = w.protocol;
      req_bus.slot_index = w.slot_index;
      req_bus.slot_generation = w.slot_generation;
      req_bus.valid = 1'b1;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      words_sent++;
   endtask

   function automatic req_type usb_word(input logic [2:0] op, input logic [6:0] addr,
                                        input logic [7:0] intf);
      req_type w;
      w = '0;
      w.opcode = op;
      w.usb_address = addr;
      w.usb_interface = intf;
      w.vendor_id = 16'h1209;
      w.product_id = 16'h0001;
      w.protocol = 4'd3;
      return w;
   endfunction

   function automatic req_type bt_word(input logic [2:0] op, input logic [1:0] tr,
                                       input logic [11:0] conn, input logic [7:0] svc);
      req_type w;
      w = '0;
      w.opcode = op;
      w.transport = tr;
      w.bt_connection = conn;
      w.bt_service = svc;
      return w;
   endfunction

   function automatic req_type id_word(input logic [2:0] op, input logic [7:0] idx,
                                       input logic [15:0] gen);
      req_type w;
      w = '0;
      w.opcode = op;
      w.slot_index = idx;
      w.slot_generation = gen;
      return w;
   endfunction

   function automatic req_type random_word();
      req_type      w;
      logic [127:0] noise;
      int           pick;
      int           idx;
      noise = {$urandom, $urandom, $urandom, $urandom};
      w = noise[99:0];
      pick = $urandom_range(0, 99);
      if (pick < 8)
         return w;
      if ($urandom_range(0, 99) < 85) begin
         w.usb_address = 7'($urandom_range(0, 3));
         w.usb_interface = 8'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 99) < 85) begin
         w.bt_connection = 12'($urandom_range(0, 2));
         w.bt_service = 8'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 99) < 90)
         w.transport = $urandom_range(0, 1) ? TR_LE : TR_CLASSIC;
      if (pick < 38)
         w.opcode = OP_CONN_USB;
      else if (pick < 62)
         w.opcode = OP_CONN_BT;
      else if (pick < 72)
         w.opcode = OP_DISC_ID;
      else if (pick < 82)
         w.opcode = OP_DISC_USB;
      else if (pick < 90)
         w.opcode = OP_DISC_BT;
      else
         w.opcode = OP_LOOKUP;
      if ((w.opcode == OP_DISC_ID || w.opcode == OP_LOOKUP) &&
          $urandom_range(0, 99) < 85) begin
         idx = $urandom_range(0, SLOTS - 1);
         w.slot_index = 8'(idx);
         w.slot_generation = known_gen[idx];
         if ($urandom_range(0, 9) == 0)
            w.slot_generation += 16'd1;
      end
      return w;
   endfunction

   // answer side: random stalls, plus the long hold-off when asked
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_done < holds_asked) begin
            holds_done++;
            rsp_bus.ready = 1'b0;
            repeat (HOLD_CYCLES - 1)
               @(negedge clock);
         end else begin
            rsp_bus.ready = calm || ($urandom_range(0, 99) >= 7);
         end
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("generational_connection_slot_table: mismatch");
      $finish;
   end

   initial begin
      req_type w;
      req_bus.valid = 1'b0;
      req_bus.opcode = '0;
      req_bus.transport = '0;
      req_bus.usb_address = '0;
      req_bus.usb_interface = '0;
      req_bus.bt_connection = '0;
      req_bus.bt_service = '0;
      req_bus.vendor_id = '0;
      req_bus.product_id = '0;
      req_bus.protocol = '0;
      req_bus.slot_index = '0;
      req_bus.slot_generation = '0;
      repeat (3)
         @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_word(id_word(OP_LOOKUP, 8'd0, 16'd0));
      w = usb_word(OP_CONN_USB, 7'h7F, 8'hFF);
      w.vendor_id = 16'hFFFF;
      w.product_id = 16'hFFFF;
      w.protocol = 4'hF;
      send_word(w);
      send_word(w);
      send_word(bt_word(OP_CONN_BT, TR_USB, 12'h123, 8'h45));
      send_word(bt_word(OP_CONN_BT, TR_OTHER, 12'h123, 8'h45));
      send_word(bt_word(OP_CONN_BT, TR_CLASSIC, 12'hFFF, 8'hFF));
      send_word(bt_word(OP_CONN_BT, TR_LE, 12'hFFF, 8'hFF));
      send_word(id_word(OP_LOOKUP, 8'd0, 16'd1));
      send_word(id_word(OP_LOOKUP, 8'd1, 16'd1));
      send_word(id_word(OP_LOOKUP, 8'hFF, 16'd1));
      send_word(id_word(OP_LOOKUP, 8'(SLOTS), 16'd1));
      send_word(id_word(OP_LOOKUP, 8'd0, 16'hFFFF));
      send_word(bt_word(OP_DISC_BT, TR_LE, 12'hFFF, 8'hFF));
      send_word(bt_word(OP_DISC_BT, TR_OTHER, 12'hFFF, 8'hFF));
      send_word(id_word(OP_DISC_ID, 8'd0, 16'd1));
      send_word(id_word(OP_LOOKUP, 8'd0, 16'd1));
      w = '1;
      w.opcode = OP_SPARE_A;
      send_word(w);
      w.opcode = OP_SPARE_B;
      send_word(w);
      // fill the table; the last connect finds no free slot
      for (int a = 0; a < SLOTS; a++)
         send_word(usb_word(OP_CONN_USB, 7'(a), 8'd0));

      // empty the table, then claim and release one slot over and over
      calm = 1'b1;
      send_word(bt_word(OP_DISC_BT, TR_CLASSIC, 12'hFFF, 8'hFF));
      for (int a = 0; a < SLOTS; a++)
         send_word(usb_word(OP_DISC_USB, 7'(a), 8'd0));
      for (int n = 0; n < WRAP_PAIRS; n++) begin
         send_word(usb_word(OP_CONN_USB, 7'h55, 8'hAA));
         send_word(usb_word(OP_DISC_USB, 7'h55, 8'hAA));
      end
      calm = 1'b0;

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         calm = (i >= 500 && i < 650);
         if (i == 300)
            holds_asked++;
         send_word(random_word());
      end
      @(negedge clock);
      req_bus.valid = 1'b0;

      while (pending != 0)
         @(negedge clock);
      repeat (SLOTS + 8)
         @(negedge clock);

      $display("summary: %0d request words sent, %0d answers checked, %0d of them ok",
               words_sent, words_checked, ok_count);
      $display("summary: full table, bad transports, id checks, slot reuse, %0d-cycle stall",
               HOLD_CYCLES);
      if (fail_count == 0)
         $display("generational_connection_slot_table: match");
      else
         $display("generational_connection_slot_table: mismatch");
      $finish;
   end

endmodule
`default_nettype wire
